// ----- src/rmq_pkg.sv -----
package rmq_pkg;

    localparam int ID_W    = 15;
    localparam int GRADE_W = 32;

    localparam logic KIND_UPDATE = 1'b0;
    localparam logic KIND_QUERY  = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic start;     // query beat accepted
        logic wr;        // update beat accepted
        logic rd;        // read one entry, advance scan pointer
        logic load_out;  // copy running max into result register
    } ctl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic beyond;    // first_id outside the table
        logic at_end;    // scan pointer sits on the last entry of the range
    } dp_stat_t;

endpackage

// ----- src/rmq_if.sv -----
interface rmq_req_if;
    logic                                valid;
    logic                                ready;
    logic                                kind;
    logic [rmq_pkg::ID_W-1:0]            first_id;
    logic [rmq_pkg::ID_W-1:0]            last_id;
    logic signed [rmq_pkg::GRADE_W-1:0]  new_grade;

    modport source (output valid, kind, first_id, last_id, new_grade, input ready);
    modport sink   (input valid, kind, first_id, last_id, new_grade, output ready);
endinterface

interface rmq_rsp_if;
    logic                                valid;
    logic                                ready;
    logic signed [rmq_pkg::GRADE_W-1:0]  max_grade;

    modport source (output valid, max_grade, input ready);
    modport sink   (input valid, max_grade, output ready);
endinterface

// ----- src/range_max_query_table_core.sv -----
// Range maximum query table with point update.
// Update: written on the accept edge; the next beat may follow in the next cycle.
// Query: scans N entries (clamped range, 1..TABLE_DEPTH), one table read per cycle
//   on the single read port, then folds in the last word and loads the result.
// Query with first_id past the table: skips the scan and answers 0. Input reopens with the result.
// Reset clears control only; table contents are undefined until written.
module range_max_query_table_core
#(
    parameter int TABLE_DEPTH = 32768
)
(
    input  logic      clk,
    input  logic      rst_n,
    rmq_req_if.sink   req,
    rmq_rsp_if.source rsp
);

    // Controller owns the handshakes and the scan sequence:
    //   IDLE  -> takes beats; updates are written on the accept edge
    //   SCAN  -> one read per cycle from first to end of range
    //   DRAIN -> folds in the last read word
    //   DONE  -> hands the max to the result register once it is free
    // The result register lets a new beat enter while the result waits.
    rmq_pkg::ctl_cmd_t cmd;
    rmq_pkg::dp_stat_t stat;

    rmq_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_kind  (req.kind),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Datapath: score memory, range setup, scan pointer, running max
    // and result register.
    rmq_datapath
    #(
        .TABLE_DEPTH (TABLE_DEPTH)
    )
    u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .first_id  (req.first_id),
        .last_id   (req.last_id),
        .new_grade (req.new_grade),
        .cmd       (cmd),
        .stat      (stat),
        .max_grade (rsp.max_grade)
    );

endmodule

// ----- src/rmq_ctrl.sv -----
module rmq_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    input  logic              req_kind,
    output logic              req_ready,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    input  rmq_pkg::dp_stat_t stat,
    output rmq_pkg::ctl_cmd_t cmd
);

    rmq_pkg::state_t state_reg;
    rmq_pkg::state_t state_next;
    logic            rsp_valid_reg;
    logic            rsp_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rmq_pkg::ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        rsp_valid_next = rsp_valid_reg;
        req_ready      = 1'b0;
        cmd            = '0;

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            rmq_pkg::ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    if (req_kind == rmq_pkg::KIND_UPDATE)
                    begin
                        cmd.wr = 1'b1;
                    end
                    else
                    begin
                        cmd.start  = 1'b1;
                        state_next = stat.beyond ? rmq_pkg::ST_DONE : rmq_pkg::ST_SCAN;
                    end
                end
            end
            rmq_pkg::ST_SCAN:
            begin
                cmd.rd = 1'b1;
                if (stat.at_end)
                begin
                    state_next = rmq_pkg::ST_DRAIN;
                end
            end
            rmq_pkg::ST_DRAIN:
            begin
                // last read word is folded into the max this cycle
                state_next = rmq_pkg::ST_DONE;
            end
            rmq_pkg::ST_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    cmd.load_out   = 1'b1;
                    rsp_valid_next = 1'b1;
                    state_next     = rmq_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rmq_pkg::ST_IDLE;
            end
        endcase
    end

    assign rsp_valid = rsp_valid_reg;

endmodule

// ----- src/rmq_datapath.sv -----
module rmq_datapath
#(
    parameter int TABLE_DEPTH = 32768
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic [rmq_pkg::ID_W-1:0]           first_id,
    input  logic [rmq_pkg::ID_W-1:0]           last_id,
    input  logic signed [rmq_pkg::GRADE_W-1:0] new_grade,
    input  rmq_pkg::ctl_cmd_t                  cmd,
    output rmq_pkg::dp_stat_t                  stat,
    output logic signed [rmq_pkg::GRADE_W-1:0] max_grade
);

    localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int WIDE_W = ((ADDR_W > rmq_pkg::ID_W) ? ADDR_W : rmq_pkg::ID_W) + 1;
    localparam logic [WIDE_W-1:0] DEPTH_W = WIDE_W'(TABLE_DEPTH);
    localparam logic [WIDE_W-1:0] TOP_W   = WIDE_W'(TABLE_DEPTH - 1);

    logic signed [rmq_pkg::GRADE_W-1:0] mem [TABLE_DEPTH];

    logic [WIDE_W-1:0]                  first_w;
    logic [WIDE_W-1:0]                  last_w;
    logic [WIDE_W-1:0]                  last_clamp;
    logic [WIDE_W-1:0]                  end_w;
    logic [ADDR_W-1:0]                  cur_reg;
    logic [ADDR_W-1:0]                  end_reg;
    logic                               first_pend_reg;
    logic                               rd_v_reg;
    logic                               rd_first_reg;
    logic signed [rmq_pkg::GRADE_W-1:0] rd_data_reg;
    logic signed [rmq_pkg::GRADE_W-1:0] best_reg;
    logic signed [rmq_pkg::GRADE_W-1:0] out_reg;

    // range setup: clamp to table top, reversed range collapses to first
    always_comb
    begin
        first_w    = WIDE_W'(first_id);
        last_w     = WIDE_W'(last_id);
        last_clamp = (last_w >= DEPTH_W) ? TOP_W : last_w;
        end_w      = (last_clamp < first_w) ? first_w : last_clamp;
    end

    assign stat.beyond = (first_w >= DEPTH_W);
    assign stat.at_end = (cur_reg == end_reg);

    // score table: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.wr && !stat.beyond)
        begin
            mem[first_w[ADDR_W-1:0]] <= new_grade;
        end
        if (cmd.rd)
        begin
            rd_data_reg <= mem[cur_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_v_reg       <= 1'b0;
            rd_first_reg   <= 1'b0;
            first_pend_reg <= 1'b0;
        end
        else
        begin
            rd_v_reg <= cmd.rd;
            if (cmd.start)
            begin
                first_pend_reg <= 1'b1;
            end
            else if (cmd.rd)
            begin
                first_pend_reg <= 1'b0;
            end
            if (cmd.rd)
            begin
                rd_first_reg <= first_pend_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            cur_reg <= first_w[ADDR_W-1:0];
            end_reg <= end_w[ADDR_W-1:0];
            if (stat.beyond)
            begin
                best_reg <= '0;
            end
        end
        else if (cmd.rd)
        begin
            cur_reg <= cur_reg + 1'b1;
        end

        if (rd_v_reg && (rd_first_reg || (rd_data_reg > best_reg)))
        begin
            best_reg <= rd_data_reg;
        end

        if (cmd.load_out)
        begin
            out_reg <= best_reg;
        end
    end

    assign max_grade = out_reg;

endmodule

// ----- src/rmq_checker.sv -----
module rmq_checker
(
    input logic                               clk,
    input logic                               rst_n,
    input logic                               req_valid,
    input logic                               req_ready,
    input logic                               req_kind,
    input logic                               rsp_valid,
    input logic                               rsp_ready,
    input logic signed [rmq_pkg::GRADE_W-1:0] rsp_max_grade
);

    logic req_beat;
    assign req_beat = req_valid && req_ready;

    // stalled result holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_max_grade))
        else $error("result changed while stalled");

    // after an update the input is ready again in the next cycle
    a_upd_ready: assert property (@(posedge clk) disable iff (!rst_n)
        req_beat && (req_kind == rmq_pkg::KIND_UPDATE) |=> req_ready)
        else $error("input not reopened after update");

    // query occupies the block
    a_qry_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_beat && (req_kind == rmq_pkg::KIND_QUERY) |=> !req_ready)
        else $error("input open right after query");

    // updates never produce a result
    a_upd_nores: assert property (@(posedge clk) disable iff (!rst_n)
        req_beat && (req_kind == rmq_pkg::KIND_UPDATE) |=> !$rose(rsp_valid))
        else $error("result raised by update");

endmodule

bind range_max_query_table_core rmq_checker u_rmq_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (req.valid),
    .req_ready     (req.ready),
    .req_kind      (req.kind),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .rsp_max_grade (rsp.max_grade)
);

// ----- tb/tb_range_max_query_table_core.sv -----
`timescale 1ns / 100ps

module tb_range_max_query_table_core;

    // A small, non-power-of-two table keeps scans short and leaves most of
    // the 15-bit ID space outside the table, so the out-of-range cases occur.
    localparam int TBL_DEPTH       = 40;
    localparam int ID_SPAN         = 1 << rmq_pkg::ID_W;
    localparam int LOAD_BEATS      = TBL_DEPTH;
    localparam int RANDOM_BEATS    = 36;
    localparam int HOLD_CYCLES     = 400;
    localparam int WATCHDOG_CYCLES = 200000;

    localparam logic signed [rmq_pkg::GRADE_W-1:0] GRADE_MIN =
        {1'b1, {(rmq_pkg::GRADE_W-1){1'b0}}};
    localparam logic signed [rmq_pkg::GRADE_W-1:0] GRADE_MAX = ~GRADE_MIN;

    typedef struct packed {
        logic                               kind;
        logic [rmq_pkg::ID_W-1:0]           first_id;
        logic [rmq_pkg::ID_W-1:0]           last_id;
        logic signed [rmq_pkg::GRADE_W-1:0] new_grade;
    } rmq_beat_t;

    // The flop initializer holds rst_n high for zero time; the #0 in the
    // reset process then gives every always block a clean falling edge.
    logic clk   = 1'b0;
    logic rst_n = 1'b1;

    rmq_req_if req_bus ();
    rmq_rsp_if rsp_bus ();

    range_max_query_table_core #(
        .TABLE_DEPTH(TBL_DEPTH)
    ) i_dut (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req_bus),
        .rsp  (rsp_bus)
    );

    // Mirror of the score table and the maxima still owed by the block.
    logic signed [rmq_pkg::GRADE_W-1:0] grades [TBL_DEPTH];
    logic signed [rmq_pkg::GRADE_W-1:0] expected_max [$];
    rmq_beat_t                          pending [$];

    rmq_beat_t                          held;
    logic signed [rmq_pkg::GRADE_W-1:0] want;
    int unsigned                        idle_left;
    int unsigned                        stall_left;
    logic                               hold_off;

    int unsigned n_accepted;
    int unsigned n_updates;
    int unsigned n_queries;
    int unsigned n_results;
    int unsigned n_errors;

    //--------------------------------------------------------------------
    // Predictor: apply one accepted beat to the mirror table. A query
    // pushes the maximum over first_id..min(last_id, end of table); a
    // reversed range reduces to the entry at first_id, and a start past
    // the table answers 0. Updates past the table are dropped.
    //--------------------------------------------------------------------
    function automatic void apply_beat(input rmq_beat_t b);
        int                                 lo;
        int                                 hi;
        logic signed [rmq_pkg::GRADE_W-1:0] best;
        lo = int'(b.first_id);
        hi = (int'(b.last_id) >= TBL_DEPTH) ? TBL_DEPTH - 1 : int'(b.last_id);
        if (b.kind == rmq_pkg::KIND_UPDATE)
        begin
            if (lo < TBL_DEPTH)
                grades[lo] = b.new_grade;
        end
        else
        begin
            if (lo >= TBL_DEPTH)
                best = '0;
            else
            begin
                best = grades[lo];
                for (int id = lo + 1; id <= hi; id++)
                    if (grades[id] > best)
                        best = grades[id];
            end
            expected_max.push_back(best);
        end
    endfunction

    // Idle length after a beat: mostly none or short, now and then long.
    // During calm stretches there is no idling at all.
    function automatic int unsigned idle_len(input bit calm);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm || r < 45)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic push_beat(input logic kind, input int unsigned first,
                             input int unsigned last,
                             input logic signed [rmq_pkg::GRADE_W-1:0] grade);
        rmq_beat_t b;
        b.kind      = kind;
        b.first_id  = first[rmq_pkg::ID_W-1:0];
        b.last_id   = last[rmq_pkg::ID_W-1:0];
        b.new_grade = grade;
        pending.push_back(b);
    endtask

    function automatic logic signed [rmq_pkg::GRADE_W-1:0] rand_grade();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return GRADE_MIN;
        if (r == 1)
            return GRADE_MAX;
        if (r == 2)
            return $signed($urandom_range(0, 15)) - 8;
        return $urandom();
    endfunction

    //--------------------------------------------------------------------
    // Clock and reset
    //--------------------------------------------------------------------
    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #0 rst_n = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    //--------------------------------------------------------------------
    // Request driver: holds each beat until accepted, predicts on accept,
    // then idles for a random number of cycles before the next beat.
    //--------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_bus.valid     <= 1'b0;
            req_bus.kind      <= rmq_pkg::KIND_UPDATE;
            req_bus.first_id  <= '0;
            req_bus.last_id   <= '0;
            req_bus.new_grade <= '0;
            idle_left = 0;
        end
        else
        begin
            if (req_bus.valid && req_bus.ready)
            begin
                apply_beat(held);
                n_accepted++;
                if (held.kind == rmq_pkg::KIND_UPDATE)
                    n_updates++;
                else
                    n_queries++;
                idle_left = idle_len((n_accepted % 50) < 15);
            end
            if (!req_bus.valid || req_bus.ready)
            begin
                if (idle_left > 0)
                begin
                    idle_left--;
                    req_bus.valid <= 1'b0;
                end
                else if (pending.size() > 0)
                begin
                    held = pending.pop_front();
                    req_bus.valid     <= 1'b1;
                    req_bus.kind      <= held.kind;
                    req_bus.first_id  <= held.first_id;
                    req_bus.last_id   <= held.last_id;
                    req_bus.new_grade <= held.new_grade;
                end
                else
                    req_bus.valid <= 1'b0;
            end
        end
    end

    //--------------------------------------------------------------------
    // Result monitor: checks each accepted result against the oldest
    // expected maximum and throttles ready with random stalls.
    //--------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_bus.ready <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (rsp_bus.valid && rsp_bus.ready)
            begin
                n_results++;
                if (expected_max.size() == 0)
                begin
                    $error("max_grade: no result expected, got %0d", rsp_bus.max_grade);
                    n_errors++;
                end
                else
                begin
                    want = expected_max.pop_front();
                    if (rsp_bus.max_grade !== want)
                    begin
                        $error("max_grade: expected %0d, got %0d", want, rsp_bus.max_grade);
                        n_errors++;
                    end
                end
                stall_left = idle_len((n_results % 20) < 6);
            end
            if (hold_off)
                rsp_bus.ready <= 1'b0;
            else if (stall_left > 0)
            begin
                stall_left--;
                rsp_bus.ready <= 1'b0;
            end
            else
                rsp_bus.ready <= 1'b1;
        end
    end

    // Back-pressure: once the random traffic is under way, refuse results
    // for a long stretch so the block holds a result and stalls its input
    // while the driver keeps offering beats.
    initial
    begin
        hold_off = 1'b0;
        while (n_accepted < LOAD_BEATS + 26)
            @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    initial
    begin
        #(WATCHDOG_CYCLES * 10);
        $display("Regression FAIL");
        $finish;
    end

    //--------------------------------------------------------------------
    // Stimulus and end of run
    //--------------------------------------------------------------------
    initial
    begin
        int unsigned r;
        int unsigned f;
        int unsigned l;

        n_accepted = 0;
        n_updates  = 0;
        n_queries  = 0;
        n_results  = 0;
        n_errors   = 0;

        // Fill the whole table first; no entry is read before it is written.
        for (int id = 0; id < LOAD_BEATS; id++)
            push_beat(rmq_pkg::KIND_UPDATE, id, $urandom_range(0, ID_SPAN - 1), $urandom());

        // Extremes at both ends of the table.
        push_beat(rmq_pkg::KIND_UPDATE, 0, ID_SPAN - 1, GRADE_MIN);
        push_beat(rmq_pkg::KIND_UPDATE, TBL_DEPTH - 1, 0, GRADE_MAX);
        push_beat(rmq_pkg::KIND_QUERY, 0, 0, 0);
        push_beat(rmq_pkg::KIND_QUERY, TBL_DEPTH - 1, TBL_DEPTH - 1, GRADE_MIN);
        push_beat(rmq_pkg::KIND_QUERY, 0, TBL_DEPTH - 1, -1);
        // Range end past the table is clamped.
        push_beat(rmq_pkg::KIND_QUERY, 0, ID_SPAN - 1, 0);
        push_beat(rmq_pkg::KIND_QUERY, TBL_DEPTH - 2, TBL_DEPTH, 0);
        // Reversed range answers the entry at first_id.
        push_beat(rmq_pkg::KIND_QUERY, 10, 3, 0);
        push_beat(rmq_pkg::KIND_QUERY, TBL_DEPTH - 1, 0, 0);
        push_beat(rmq_pkg::KIND_QUERY, 1, 0, 0);
        // Start past the table answers 0.
        push_beat(rmq_pkg::KIND_QUERY, TBL_DEPTH, TBL_DEPTH, 0);
        push_beat(rmq_pkg::KIND_QUERY, ID_SPAN - 1, 0, GRADE_MAX);
        push_beat(rmq_pkg::KIND_QUERY, ID_SPAN / 2, ID_SPAN - 1, 0);
        // Updates past the table must leave it untouched.
        push_beat(rmq_pkg::KIND_UPDATE, TBL_DEPTH, 0, GRADE_MAX);
        push_beat(rmq_pkg::KIND_UPDATE, ID_SPAN - 1, ID_SPAN - 1, GRADE_MAX);
        // All-negative stretch; entry 0 holds the minimum.
        push_beat(rmq_pkg::KIND_UPDATE, 1, 0, -5);
        push_beat(rmq_pkg::KIND_UPDATE, 2, 0, -3);
        push_beat(rmq_pkg::KIND_UPDATE, 3, 0, GRADE_MIN);
        push_beat(rmq_pkg::KIND_QUERY, 1, 3, 0);
        push_beat(rmq_pkg::KIND_QUERY, 0, 3, 0);
        // Back-to-back overwrites of one entry.
        push_beat(rmq_pkg::KIND_UPDATE, 2, 0, 7);
        push_beat(rmq_pkg::KIND_UPDATE, 2, 0, -7);
        push_beat(rmq_pkg::KIND_QUERY, 2, 2, 0);
        push_beat(rmq_pkg::KIND_QUERY, TBL_DEPTH - 3, ID_SPAN - 1, 0);

        for (int i = 0; i < RANDOM_BEATS; i++)
        begin
            r = $urandom_range(0, 99);
            f = $urandom_range(0, TBL_DEPTH - 1);
            if (r < 35)
                push_beat(rmq_pkg::KIND_UPDATE, f, $urandom_range(0, ID_SPAN - 1),
                          rand_grade());
            else if (r < 40)
                push_beat(rmq_pkg::KIND_UPDATE, $urandom_range(TBL_DEPTH, ID_SPAN - 1),
                          $urandom_range(0, ID_SPAN - 1), $urandom());
            else if (r < 70)
                push_beat(rmq_pkg::KIND_QUERY, f, f + $urandom_range(0, 5), $urandom());
            else if (r < 78)
                push_beat(rmq_pkg::KIND_QUERY, $urandom_range(0, 3),
                          $urandom_range(TBL_DEPTH - 4, ID_SPAN - 1), $urandom());
            else if (r < 86)
            begin
                f = $urandom_range(1, TBL_DEPTH - 1);
                push_beat(rmq_pkg::KIND_QUERY, f, $urandom_range(0, f - 1), $urandom());
            end
            else if (r < 92)
                push_beat(rmq_pkg::KIND_QUERY, $urandom_range(TBL_DEPTH, ID_SPAN - 1),
                          $urandom_range(0, ID_SPAN - 1), $urandom());
            else
            begin
                l = $urandom_range(0, ID_SPAN - 1);
                push_beat(rmq_pkg::KIND_QUERY, f, l, $urandom());
            end
        end

        while (!rst_n)
            @(posedge clk);
        while (pending.size() > 0 || req_bus.valid)
            @(posedge clk);
        while (expected_max.size() > 0)
            @(posedge clk);
        // A full-table scan is the longest the block can still be busy.
        repeat (TBL_DEPTH + 10) @(posedge clk);

        $display("Run covered %0d updates and %0d range queries on a %0d-entry table,",
                 n_updates, n_queries, TBL_DEPTH);
        $display("with %0d maxima checked under random gaps and a long result hold-off.",
                 n_results);
        if (n_errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ----- filelist.f -----
src/rmq_pkg.sv
src/rmq_if.sv
src/rmq_ctrl.sv
src/rmq_datapath.sv
src/range_max_query_table_core.sv
src/rmq_checker.sv
tb/tb_range_max_query_table_core.sv
